>>> src/hta_pkg.sv
// ----------------------------------------------------------------------------
// Handle table allocator package
// Shared widths, request and status codes, state encoding and defaults.
// ----------------------------------------------------------------------------
package hta_pkg;

  localparam int unsigned KIND_W      = 2;
  localparam int unsigned HANDLE_W    = 8;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DATA_W      = HANDLE_W + VALUE_W;

  // handles fit in eight bits, so no more slots than this are reachable
  localparam int unsigned HANDLE_SPAN = 256;
  localparam int unsigned DEFAULT_CAPACITY = 256;

  // the free search works on groups of this many used bits
  localparam int unsigned GROUP_SIZE  = 16;
  localparam int unsigned GROUP_IDX_W = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_ZERO_VALUE  = 2'd2,
    STAT_HANDLE_ZERO = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

>>> src/hta_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module hta_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr_i,
  input  logic [WIDTH-1:0]                                wdata_i,
  input  logic                                            re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr_i,
  output logic [WIDTH-1:0]                                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/handle_table_allocator_top.sv
// ----------------------------------------------------------------------------
// Handle table allocator, top level
// Result: registered in the execute state once no earlier result beat
//   waits, and held there until the result side accepts it.
// Flow: a request is taken only when idle, so none while one executes; the
//   value RAM is read on accept and written back in the execute state.
// Reset: used bits clear at once in flip-flops; the value RAM needs no
//   clearing pass, so requests are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module handle_table_allocator_top #(
  parameter int unsigned CAPACITY = hta_pkg::DEFAULT_CAPACITY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] handle, [71:8] value
  input  logic [hta_pkg::DATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [hta_pkg::KIND_W-1:0] s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [7:0] handle_out, [71:8] value_out
  output logic [hta_pkg::DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [hta_pkg::STATUS_W-1:0] m_axis_tuser
);

  localparam int unsigned SLOTS   = (CAPACITY < hta_pkg::HANDLE_SPAN) ?
                                    CAPACITY : hta_pkg::HANDLE_SPAN;
  localparam int unsigned ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NGROUPS = (SLOTS + hta_pkg::GROUP_SIZE - 1) /
                                    hta_pkg::GROUP_SIZE;
  localparam int unsigned NGW     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int unsigned PW      = NGROUPS * hta_pkg::GROUP_SIZE;
  localparam int unsigned PIW     = NGW + hta_pkg::GROUP_IDX_W;

  hta_pkg::state_e state_q, state_d;

  // request held for the execute state
  hta_pkg::kind_e                 req_kind_q;
  logic [hta_pkg::HANDLE_W-1:0]   req_handle_q;
  logic [hta_pkg::VALUE_W-1:0]    req_value_q;

  // slot 0 and padding bits stay set so the search never picks them
  logic [PW-1:0]      used_q, used_d;
  logic [NGROUPS-1:0] grp_full_q, grp_full_d;

  logic                            out_valid_q, out_valid_d;
  logic [hta_pkg::DATA_W-1:0]      out_data_q, out_data_d;
  logic [hta_pkg::STATUS_W-1:0]    out_user_q, out_user_d;

  logic                            accept;
  logic                            complete;
  logic [NGW-1:0]                  grp_sel;
  logic [hta_pkg::GROUP_SIZE-1:0]  grp_bits;
  logic [hta_pkg::GROUP_IDX_W-1:0] bit_sel;
  logic [PIW-1:0]                  free_idx;
  logic                            table_full;
  logic                            in_range;
  logic                            slot_used;

  logic                            ram_we;
  logic [hta_pkg::VALUE_W-1:0]     ram_rdata;

  hta_ram #(
    .WIDTH (hta_pkg::VALUE_W),
    .DEPTH (SLOTS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx[ADDR_W-1:0]),
    .wdata_i (req_value_q),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign complete = (state_q == hta_pkg::S_EXEC) && (!out_valid_q || m_axis_tready);

  // ---- first-free search: lowest non-full group, then lowest clear bit ----
  always_comb begin
    grp_sel = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (!grp_full_q[g]) begin
        grp_sel = NGW'(g);
      end
    end
  end

  assign grp_bits = used_q[{grp_sel, hta_pkg::GROUP_IDX_W'(0)} +: hta_pkg::GROUP_SIZE];

  always_comb begin
    bit_sel = '0;
    for (int b = hta_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        bit_sel = hta_pkg::GROUP_IDX_W'(b);
      end
    end
  end

  assign free_idx   = {grp_sel, bit_sel};
  assign table_full = &grp_full_q;
  assign in_range   = (32'(req_handle_q) < CAPACITY);
  assign slot_used  = used_q[req_handle_q[PIW-1:0]];

  assign ram_we = complete && (req_kind_q == hta_pkg::KIND_ALLOC) &&
                  (req_value_q != '0) && !table_full;

  // ---- state machine ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      hta_pkg::S_IDLE: begin
        if (accept) state_d = hta_pkg::S_EXEC;
      end
      hta_pkg::S_EXEC: begin
        if (complete) state_d = hta_pkg::S_IDLE;
      end
      default: state_d = hta_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      hta_pkg::S_IDLE: s_axis_tready = 1'b1;
      hta_pkg::S_EXEC: s_axis_tready = 1'b0;
      default:         s_axis_tready = 1'b0;
    endcase
  end

  // ---- used bits and result ----
  always_comb begin
    logic [hta_pkg::HANDLE_W-1:0] h_out;
    logic [hta_pkg::VALUE_W-1:0]  v_out;
    hta_pkg::status_e             st;

    used_d = used_q;
    h_out  = '0;
    v_out  = '0;
    st     = hta_pkg::STAT_OK;

    case (req_kind_q)
      hta_pkg::KIND_ALLOC: begin
        if (req_value_q == '0) begin
          st = hta_pkg::STAT_ZERO_VALUE;
        end else if (table_full) begin
          st = hta_pkg::STAT_FULL;
        end else begin
          h_out = hta_pkg::HANDLE_W'(free_idx);
          if (complete) used_d[free_idx] = 1'b1;
        end
      end
      hta_pkg::KIND_LOOKUP: begin
        if (req_handle_q == '0) begin
          st = hta_pkg::STAT_HANDLE_ZERO;
        end else if (in_range && slot_used) begin
          v_out = ram_rdata;
        end
      end
      hta_pkg::KIND_FREE: begin
        if (req_handle_q == '0) begin
          st = hta_pkg::STAT_HANDLE_ZERO;
        end else if (in_range && complete) begin
          used_d[req_handle_q[PIW-1:0]] = 1'b0;
        end
      end
      default: ;
    endcase

    for (int g = 0; g < NGROUPS; g++) begin
      grp_full_d[g] = &used_d[g*hta_pkg::GROUP_SIZE +: hta_pkg::GROUP_SIZE];
    end

    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (complete) begin
      out_valid_d = 1'b1;
      out_data_d  = {v_out, h_out};
      out_user_d  = st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hta_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      grp_full_q  <= '0;
      for (int i = 0; i < PW; i++) begin
        used_q[i] <= (i == 0) || (i >= SLOTS);
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      grp_full_q  <= grp_full_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_kind_q   <= hta_pkg::kind_e'(s_axis_tuser);
      req_handle_q <= s_axis_tdata[hta_pkg::HANDLE_W-1:0];
      req_value_q  <= s_axis_tdata[hta_pkg::DATA_W-1:hta_pkg::HANDLE_W];
    end
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> src/hta_checker.sv
// ----------------------------------------------------------------------------
// Handle table allocator port checker
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module hta_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [hta_pkg::DATA_W-1:0]   m_axis_tdata,
  input logic [hta_pkg::STATUS_W-1:0] m_axis_tuser
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one request in flight: no new beat straight after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one still executing");

  // any failure status carries no handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != hta_pkg::STAT_OK)
      |-> m_axis_tdata[hta_pkg::HANDLE_W-1:0] == '0)
    else $error("handle returned with failure status");

  // an allocated handle never comes with a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[hta_pkg::HANDLE_W-1:0] != '0)
      |-> m_axis_tdata[hta_pkg::DATA_W-1:hta_pkg::HANDLE_W] == '0)
    else $error("allocation result carries a value");

endmodule

bind handle_table_allocator_top hta_checker u_hta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
